// File: rtl/core/sbe_pkg.sv
// Shared types and constants of the sixel band encoder.
package sbe_pkg;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_CHK,
    ST_LD_CLR,
    ST_LD_MRD,
    ST_LD_MWR,
    ST_LD_ADV,
    ST_EM_MM,
    ST_EM_SEL,
    ST_RUN_V,
    ST_RUN_SCAN,
    ST_RUN_OUT
  } ctl_state_t;

  // Emission phase of the pending band.
  typedef enum logic [2:0] {
    PH_DOLLAR,
    PH_SELECT,
    PH_GAP,
    PH_RUNS,
    PH_DASH,
    PH_DONE
  } em_phase_t;

  // Token kinds.
  localparam logic [2:0] TK_NONE   = 3'd0;
  localparam logic [2:0] TK_TAKEN  = 3'd1;
  localparam logic [2:0] TK_REFUSE = 3'd2;
  localparam logic [2:0] TK_SELECT = 3'd3;
  localparam logic [2:0] TK_RUN    = 3'd4;
  localparam logic [2:0] TK_DOLLAR = 3'd5;
  localparam logic [2:0] TK_DASH   = 3'd6;

  // Request types.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_PULL  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIRST  = 2'd2;
  localparam logic [1:0] REG_END    = 2'd3;

  localparam logic [7:0] PIXEL_BASE = 8'd16;
  localparam int SIXEL_ROWS     = 6;
  localparam int RUN_REPEAT_MIN = 3;
  // Division by six as multiply and shift, exact for values below 21845.
  localparam int BANDS_RECIP    = 43691;
  localparam int BANDS_SHIFT    = 18;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_begin;
    logic       new_use;
    logic       clr_step;
    logic       ld_read;
    logic       ld_write;
    logic       advance;
    logic       em_mm;
    logic       run_v;
    logic       run_next;
    logic       emit;
    logic [2:0] kind;
    logic       gap;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic      pending;
    em_phase_t phase;
    logic      paint;
    logic      seen_hit;
    logic      clr_last;
    logic      v_stop;
    logic      scan_match;
    logic      p_stop;
  } dp_status_t;

endpackage

// File: rtl/core/sbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/sbe_datapath.sv
// Datapath of the sixel band encoder: position, band tables, memories and result beat.
module sbe_datapath import sbe_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int NUM_REGISTERS = 240,
  parameter int MAX_HEIGHT    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_restart,
  input  logic [10:0] image_width,
  input  logic [12:0] image_height,
  input  logic [9:0]  start_band,
  input  logic [9:0]  end_band,
  input  logic [7:0]  pixel_index,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        strobe,
  output logic [2:0]  token_kind,
  output logic [7:0]  color_register,
  output logic [10:0] run_count,
  output logic [5:0]  sixel_bits,
  output logic        repeat_form,
  output logic        band_last
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int BW    = $clog2((MAX_HEIGHT + 5) / 6 + 1);
  localparam int REG_W = $clog2(NUM_REGISTERS);
  localparam int CNT_W = $clog2(NUM_REGISTERS + 1);
  localparam int MDEP  = NUM_REGISTERS * MAX_WIDTH;
  localparam int MAW   = $clog2(MDEP);

  // Effective geometry.
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [31:0]   band_prod;
  logic [BW-1:0] bands;
  logic [BW-1:0] endb;

  // Load position and latched pixel.
  logic [CW-1:0]    load_col;
  logic [RW-1:0]    load_row;
  logic [2:0]       load_dy;
  logic [BW-1:0]    load_band;
  logic [REG_W-1:0] l_reg;
  logic [CW-1:0]    l_col;
  logic [2:0]       l_dy;
  logic             l_in_range;
  logic             l_paint;
  logic             in_range_now;
  logic             pix_ok;
  logic             band_end;
  logic             next_dash;

  // Band tables.
  logic [NUM_REGISTERS-1:0] seen;
  logic [CNT_W-1:0]         color_count;
  logic [CW-1:0]            clr_cnt;

  // Emission state.
  logic             pending;
  em_phase_t        phase;
  logic [CNT_W-1:0] em_ci;
  logic [CW-1:0]    em_x;
  logic             em_dash;
  logic [REG_W-1:0] cur_reg;
  logic [CW-1:0]    cur_min;
  logic [CW-1:0]    cur_max;
  logic [CW-1:0]    scan_p;
  logic [5:0]       scan_v;

  // Memory ports.
  logic             mask_we;
  logic [MAW-1:0]   mask_waddr;
  logic [5:0]       mask_wdata;
  logic [MAW-1:0]   mask_raddr;
  logic [5:0]       mask_rdata;
  logic [REG_W-1:0] mask_rreg;
  logic [CW-1:0]    mask_rcol;
  logic             mm_we;
  logic [2*CW-1:0]  mm_wdata;
  logic [REG_W-1:0] mm_raddr;
  logic [2*CW-1:0]  mm_rdata;
  logic [CW-1:0]    mm_min;
  logic [CW-1:0]    mm_max;
  logic [CW-1:0]    upd_min;
  logic [CW-1:0]    upd_max;
  logic             ord_we;
  logic [REG_W-1:0] ord_rdata;

  // Result values.
  logic [CW-1:0]    run_full;
  logic             run_end;
  logic [CNT_W-1:0] ci_next;
  logic             more_colors;
  logic             last_val;

  // Width and height saturated to the supported range; band count is ceil(h/6).
  always_comb begin
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
    band_prod = (32'(h_eff) + 32'd5) * 32'(BANDS_RECIP);
    bands     = BW'(band_prod >> BANDS_SHIFT);
    endb      = (32'(end_band) < 32'(bands)) ? BW'(end_band) : bands;
  end

  // Pixel and position conditions.
  assign in_range_now = (32'(load_band) >= 32'(start_band)) &&
                        (32'(load_band) < 32'(endb));
  assign pix_ok       = (pixel_index >= PIXEL_BASE) &&
                        ((32'(pixel_index) - 32'(PIXEL_BASE)) < NUM_REGISTERS);
  assign band_end     = (32'(load_col) + 32'd1 >= 32'(w_eff)) &&
                        ((load_dy == 3'(SIXEL_ROWS - 1)) ||
                         (32'(load_row) + 32'd1 >= 32'(h_eff)));
  assign next_dash    = (32'(load_band) + 32'd1) < 32'(bands);

  // Column mask memory: one word per register and column.
  assign mask_rreg  = cmd.ld_read ? l_reg : cur_reg;
  always_comb begin
    if (cmd.ld_read) begin
      mask_rcol = l_col;
    end else if (cmd.run_v) begin
      mask_rcol = CW'(32'(em_x) + 32'd1);
    end else if (cmd.run_next) begin
      mask_rcol = CW'(32'(scan_p) + 32'd1);
    end else begin
      mask_rcol = em_x;
    end
  end
  assign mask_raddr = MAW'(32'(mask_rreg) * MAX_WIDTH + 32'(mask_rcol));
  assign mask_we    = cmd.clr_step | cmd.ld_write;
  assign mask_waddr = MAW'(32'(l_reg) * MAX_WIDTH +
                           32'(cmd.clr_step ? clr_cnt : l_col));
  assign mask_wdata = cmd.clr_step ? 6'd0 : (mask_rdata | (6'd1 << l_dy));

  sbe_ram #(.WIDTH(6), .DEPTH(MDEP)) u_mask_ram (
    .clk  (clk),
    .we   (mask_we),
    .waddr(mask_waddr),
    .wdata(mask_wdata),
    .raddr(mask_raddr),
    .rdata(mask_rdata)
  );

  // Min and max column per register, packed as {max, min}.
  assign mm_min   = mm_rdata[CW-1:0];
  assign mm_max   = mm_rdata[2*CW-1:CW];
  always_comb begin
    upd_min = mm_min;
    upd_max = mm_max;
    if (l_col < mm_min) begin
      upd_min = l_col;
    end else if (l_col > mm_max) begin
      upd_max = l_col;
    end
  end
  assign mm_we    = cmd.new_use | cmd.ld_write;
  assign mm_wdata = cmd.new_use ? {l_col, l_col} : {upd_max, upd_min};
  assign mm_raddr = cmd.em_mm ? ord_rdata : l_reg;

  sbe_ram #(.WIDTH(2 * CW), .DEPTH(NUM_REGISTERS)) u_minmax_ram (
    .clk  (clk),
    .we   (mm_we),
    .waddr(l_reg),
    .wdata(mm_wdata),
    .raddr(mm_raddr),
    .rdata(mm_rdata)
  );

  // First-use order of registers in the band.
  assign ord_we = cmd.new_use && (32'(color_count) < NUM_REGISTERS);

  sbe_ram #(.WIDTH(REG_W), .DEPTH(NUM_REGISTERS)) u_order_ram (
    .clk  (clk),
    .we   (ord_we),
    .waddr(color_count[REG_W-1:0]),
    .wdata(l_reg),
    .raddr(em_ci[REG_W-1:0]),
    .rdata(ord_rdata)
  );

  // Status toward the controller.
  assign status.pending    = pending;
  assign status.phase      = phase;
  assign status.paint      = l_paint;
  assign status.seen_hit   = seen[l_reg];
  assign status.clr_last   = (32'(clr_cnt) + 32'd1 >= 32'(w_eff));
  assign status.v_stop     = (32'(em_x) + 32'd1 > 32'(cur_max)) ||
                             (32'(em_x) + 32'd1 >= MAX_WIDTH);
  assign status.scan_match = (mask_rdata == scan_v);
  assign status.p_stop     = (32'(scan_p) + 32'd1 > 32'(cur_max)) ||
                             (32'(scan_p) + 32'd1 >= MAX_WIDTH);

  // Run length and end-of-band decision for the beat being formed.
  always_comb begin
    if (cmd.kind != TK_RUN) begin
      run_full = '0;
    end else if (cmd.gap) begin
      run_full = cur_min;
    end else begin
      run_full = scan_p - em_x;
    end
  end
  assign run_end     = scan_p > cur_max;
  assign ci_next     = em_ci + CNT_W'(1);
  assign more_colors = ci_next < color_count;
  assign last_val    = (cmd.kind == TK_DASH) ||
                       ((cmd.kind == TK_RUN) && !cmd.gap && run_end &&
                        !more_colors && !em_dash);

  // Pixel loading: position, latched pixel, seen flags and color count.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      load_col    <= '0;
      load_row    <= '0;
      load_dy     <= '0;
      load_band   <= '0;
      seen        <= '0;
      color_count <= '0;
      l_paint     <= 1'b0;
    end else begin
      if (cmd.load_begin) begin
        l_reg      <= REG_W'(pixel_index - PIXEL_BASE);
        l_col      <= load_col;
        l_dy       <= load_dy;
        l_in_range <= in_range_now;
        l_paint    <= in_range_now && pix_ok;
        if (load_dy == 3'd0 && load_col == '0) begin
          seen        <= '0;
          color_count <= '0;
        end
      end
      if (cmd.new_use) begin
        seen[l_reg] <= 1'b1;
        clr_cnt     <= '0;
        if (32'(color_count) < NUM_REGISTERS) begin
          color_count <= color_count + CNT_W'(1);
        end
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (cmd.advance) begin
        if (32'(load_col) + 32'd1 >= 32'(w_eff)) begin
          load_col <= '0;
          if (32'(load_row) + 32'd1 >= 32'(h_eff)) begin
            load_row  <= '0;
            load_dy   <= '0;
            load_band <= '0;
          end else begin
            load_row <= load_row + RW'(1);
            if (load_dy == 3'(SIXEL_ROWS - 1)) begin
              load_dy   <= '0;
              load_band <= load_band + BW'(1);
            end else begin
              load_dy <= load_dy + 3'd1;
            end
          end
        end else begin
          load_col <= load_col + CW'(1);
        end
      end
    end
  end

  // Emission state.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      pending <= 1'b0;
      phase   <= PH_DONE;
      em_ci   <= '0;
      em_x    <= '0;
      em_dash <= 1'b0;
    end else begin
      if (cmd.advance && band_end && l_in_range) begin
        em_dash <= next_dash;
        em_ci   <= '0;
        if (color_count != '0) begin
          phase   <= PH_SELECT;
          pending <= 1'b1;
        end else if (next_dash) begin
          phase   <= PH_DASH;
          pending <= 1'b1;
        end
      end
      if (cmd.run_v) begin
        scan_v <= mask_rdata;
        scan_p <= CW'(32'(em_x) + 32'd1);
      end
      if (cmd.run_next) begin
        scan_p <= CW'(32'(scan_p) + 32'd1);
      end
      if (cmd.emit) begin
        unique case (cmd.kind)
          TK_DOLLAR: phase <= PH_SELECT;
          TK_SELECT: begin
            cur_reg <= ord_rdata;
            cur_min <= mm_min;
            cur_max <= mm_max;
            em_x    <= mm_min;
            phase   <= (mm_min != '0) ? PH_GAP : PH_RUNS;
          end
          TK_RUN: begin
            if (cmd.gap) begin
              phase <= PH_RUNS;
            end else begin
              em_x <= scan_p;
              if (run_end) begin
                em_ci <= ci_next;
                if (more_colors) begin
                  phase <= PH_DOLLAR;
                end else if (em_dash) begin
                  phase <= PH_DASH;
                end else begin
                  phase   <= PH_DONE;
                  pending <= 1'b0;
                end
              end
            end
          end
          TK_DASH: begin
            phase   <= PH_DONE;
            pending <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      token_kind     <= cmd.kind;
      color_register <= (cmd.kind == TK_SELECT) ? 8'(ord_rdata) : 8'd0;
      run_count      <= 11'(run_full);
      sixel_bits     <= (cmd.kind == TK_RUN && !cmd.gap) ? scan_v : 6'd0;
      repeat_form    <= (cmd.kind == TK_RUN) && (32'(run_full) > RUN_REPEAT_MIN);
      band_last      <= last_val;
    end
  end

endmodule

// File: rtl/core/sbe_controller.sv
// Controller state machine of the sixel band encoder.
module sbe_controller import sbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       req_type,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_PIXEL) begin
            if (status.pending) begin
              cmd.emit = 1'b1;
              cmd.kind = TK_REFUSE;
            end else begin
              cmd.load_begin = 1'b1;
              state_next     = ST_LD_CHK;
            end
          end else if (!status.pending) begin
            cmd.emit = 1'b1;
            cmd.kind = TK_NONE;
          end else begin
            unique case (status.phase)
              PH_DOLLAR: begin
                cmd.emit = 1'b1;
                cmd.kind = TK_DOLLAR;
              end
              PH_SELECT: state_next = ST_EM_MM;
              PH_GAP: begin
                cmd.emit = 1'b1;
                cmd.kind = TK_RUN;
                cmd.gap  = 1'b1;
              end
              PH_RUNS:   state_next = ST_RUN_V;
              PH_DASH: begin
                cmd.emit = 1'b1;
                cmd.kind = TK_DASH;
              end
              default: begin
                cmd.emit = 1'b1;
                cmd.kind = TK_NONE;
              end
            endcase
          end
        end
      end
      ST_LD_CHK: begin
        if (!status.paint) begin
          state_next = ST_LD_ADV;
        end else if (status.seen_hit) begin
          state_next = ST_LD_MRD;
        end else begin
          cmd.new_use = 1'b1;
          state_next  = ST_LD_CLR;
        end
      end
      ST_LD_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_LD_MRD;
        end
      end
      ST_LD_MRD: begin
        cmd.ld_read = 1'b1;
        state_next  = ST_LD_MWR;
      end
      ST_LD_MWR: begin
        cmd.ld_write = 1'b1;
        state_next   = ST_LD_ADV;
      end
      ST_LD_ADV: begin
        cmd.advance = 1'b1;
        cmd.emit    = 1'b1;
        cmd.kind    = TK_TAKEN;
        state_next  = ST_IDLE;
      end
      ST_EM_MM: begin
        cmd.em_mm  = 1'b1;
        state_next = ST_EM_SEL;
      end
      ST_EM_SEL: begin
        cmd.emit   = 1'b1;
        cmd.kind   = TK_SELECT;
        state_next = ST_IDLE;
      end
      ST_RUN_V: begin
        cmd.run_v  = 1'b1;
        state_next = status.v_stop ? ST_RUN_OUT : ST_RUN_SCAN;
      end
      ST_RUN_SCAN: begin
        if (status.scan_match) begin
          cmd.run_next = 1'b1;
          if (status.p_stop) begin
            state_next = ST_RUN_OUT;
          end
        end else begin
          state_next = ST_RUN_OUT;
        end
      end
      ST_RUN_OUT: begin
        cmd.emit   = 1'b1;
        cmd.kind   = TK_RUN;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/sixel_band_encoder_core.sv
// Top level of the sixel band encoder: configuration registers, controller and datapath.
//
//  channel   signals                                     beat taken when
//  request   start, busy, req_type, pixel_index          start && !busy
//  result    strobe, token_kind .. band_last             strobe (one cycle, no stall)
//  config    psel, penable, pwrite, paddr, pwdata, prdata psel && penable && pwrite
//
// A pixel load passes the check, mask read, mask write and advance states; one that paints
// nothing goes from check to advance, and when a register is first used in a band, its mask
// row is cleared one column a cycle through the mask memory's single write port. A pull
// is answered from idle; a color select passes the min/max read and select states, and a run
// the value read, any column scan and output state. Each result beat shows the cycle after
// the item's last cycle and cannot be stalled. Reset is synchronous, with no clearing pass.
module sixel_band_encoder_core import sbe_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int NUM_REGISTERS = 240,
  parameter int MAX_HEIGHT    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  pixel_index,
  output logic        strobe,
  output logic [2:0]  token_kind,
  output logic [7:0]  color_register,
  output logic [10:0] run_count,
  output logic [5:0]  sixel_bits,
  output logic        repeat_form,
  output logic        band_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [9:0]  start_band;
  logic [9:0]  end_band;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1;
      image_height <= 13'd1;
      start_band   <= 10'd0;
      end_band     <= 10'd683;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        REG_FIRST:  start_band   <= pwdata[9:0];
        REG_END:    end_band     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_FIRST:  prdata = 32'(start_band);
      REG_END:    prdata = 32'(end_band);
      default:    prdata = '0;
    endcase
  end

  sbe_controller u_ctl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  sbe_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .NUM_REGISTERS(NUM_REGISTERS),
    .MAX_HEIGHT   (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_restart   (cfg_wr),
    .image_width   (image_width),
    .image_height  (image_height),
    .start_band    (start_band),
    .end_band      (end_band),
    .pixel_index   (pixel_index),
    .cmd           (cmd),
    .status        (status),
    .strobe        (strobe),
    .token_kind    (token_kind),
    .color_register(color_register),
    .run_count     (run_count),
    .sixel_bits    (sixel_bits),
    .repeat_form   (repeat_form),
    .band_last     (band_last)
  );

  // A pixel offered while tokens are pending is refused in the next cycle.
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_PIXEL && status.pending
    |=> strobe && token_kind == TK_REFUSE)
    else $error("pending pixel not refused");

  // A pull with nothing pending returns an empty beat in the next cycle.
  a_none: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_PULL && !status.pending
    |=> strobe && token_kind == TK_NONE)
    else $error("idle pull not answered");

  // Only a run or a band separator closes a band.
  a_last: assert property (@(posedge clk) disable iff (rst)
    strobe && band_last |-> token_kind == TK_RUN || token_kind == TK_DASH)
    else $error("band_last on wrong token");

  // A configuration write drops any pending tokens.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !status.pending)
    else $error("pending survived config write");

endmodule
